@@ hw/rtl/wsdf_pkg.sv @@
// Package with shared types and codes of the WebSocket frame deframer.
`default_nettype none
package wsdf_pkg;

    localparam int LEN_W    = 17;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int PHASE_W  = 3;
    localparam int EXTCNT_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    localparam logic ERR_LENGTH  = 1'b0;
    localparam logic ERR_FF_BYTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_FF = 2'd1;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 17'd65536;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [BYTE_W-1:0] FORBIDDEN_BYTE = 8'hFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] plain_byte;
        logic [LEN_W-1:0]  frame_length;
        logic              last_of_frame;
        logic              error_code;
    } res_t;

    typedef struct packed {
        logic res_valid;
        logic halted;
    } parse_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/wsdf_parser.sv @@
// Frame header parser and payload unmasker, one stream word per accepted cycle.
`default_nettype none
module wsdf_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire logic [7:0]                  stream_byte,
    input  wire logic [wsdf_pkg::LEN_W-1:0]  max_len,
    input  wire logic                        reject_ff,
    output wsdf_pkg::res_t                   res,
    output wsdf_pkg::parse_stat_t            stat
);
    import wsdf_pkg::*;

    localparam logic [PHASE_W-1:0] PH_HDR0 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXT  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_MASK = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;

    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [EXTCNT_W-1:0] ext_left_reg, ext_left_next;
    logic [LEN_W-1:0]    acc_reg, acc_next;
    logic                big_reg, big_next;
    logic [31:0]         key_reg, key_next;
    logic [1:0]          mcnt_reg, mcnt_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic                halted_reg, halted_next;

    logic                res_valid;
    logic [LEN_W-1:0]    cand_acc;
    logic                cand_big;
    logic                len_done;
    logic                over;
    logic [7:0]          key_byte;
    logic                last;

    // Candidate length for the current word, used whenever a length completes.
    always_comb
    begin
        if (phase_reg == PH_HDR1)
        begin
            cand_acc = {{(LEN_W-7){1'b0}}, stream_byte[6:0]};
            cand_big = 1'b0;
        end
        else
        begin
            cand_acc = {acc_reg[LEN_W-9:0], stream_byte};
            cand_big = big_reg | (acc_reg[LEN_W-1:LEN_W-8] != 8'd0);
        end
        over = cand_big || (cand_acc > max_len);
    end

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        last = ({1'b0, idx_reg} + {{LEN_W{1'b0}}, 1'b1}) >= {1'b0, acc_reg};
    end

    always_comb
    begin
        phase_next    = phase_reg;
        ext_left_next = ext_left_reg;
        acc_next      = acc_reg;
        big_next      = big_reg;
        key_next      = key_reg;
        mcnt_next     = mcnt_reg;
        idx_next      = idx_reg;
        halted_next   = halted_reg;
        res_valid     = 1'b0;
        res           = '0;
        len_done      = 1'b0;

        if (!halted_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (stream_byte[6:0] < LEN_CODE_16)
                    begin
                        len_done = 1'b1;
                    end
                    else
                    begin
                        acc_next      = '0;
                        big_next      = 1'b0;
                        ext_left_next = (stream_byte[6:0] == LEN_CODE_16) ? 4'd2 : 4'd8;
                        phase_next    = PH_EXT;
                    end
                end
                PH_EXT:
                begin
                    ext_left_next = ext_left_reg - 4'd1;
                    acc_next      = cand_acc;
                    big_next      = cand_big;
                    if (ext_left_reg == 4'd1)
                    begin
                        len_done = 1'b1;
                    end
                end
                PH_MASK:
                begin
                    key_next  = {key_reg[23:0], stream_byte};
                    mcnt_next = mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd3)
                    begin
                        idx_next  = '0;
                        res_valid = 1'b1;
                        res.kind  = KIND_HEADER;
                        if (acc_reg == '0)
                        begin
                            phase_next        = PH_HDR0;
                            res.last_of_frame = 1'b1;
                        end
                        else
                        begin
                            phase_next       = PH_DATA;
                            res.frame_length = acc_reg;
                        end
                    end
                end
                PH_DATA:
                begin
                    res_valid = 1'b1;
                    if (reject_ff && (stream_byte == FORBIDDEN_BYTE))
                    begin
                        halted_next    = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_FF_BYTE;
                    end
                    else
                    begin
                        res.kind          = KIND_DATA;
                        res.plain_byte    = stream_byte ^ key_byte;
                        res.last_of_frame = last;
                        if (last)
                        begin
                            phase_next = PH_HDR0;
                            idx_next   = '0;
                        end
                        else
                        begin
                            idx_next = idx_reg + {{(LEN_W-1){1'b0}}, 1'b1};
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase

            // A completed length is checked against the limit in effect now.
            if (len_done)
            begin
                acc_next = cand_acc;
                big_next = cand_big;
                if (over)
                begin
                    halted_next    = 1'b1;
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_LENGTH;
                end
                else
                begin
                    phase_next = PH_MASK;
                    mcnt_next  = 2'd0;
                end
            end
        end
    end

    assign stat = {res_valid, halted_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            ext_left_reg <= '0;
            acc_reg      <= '0;
            big_reg      <= 1'b0;
            key_reg      <= '0;
            mcnt_reg     <= '0;
            idx_reg      <= '0;
            halted_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            ext_left_reg <= ext_left_next;
            acc_reg      <= acc_next;
            big_reg      <= big_next;
            key_reg      <= key_next;
            mcnt_reg     <= mcnt_next;
            idx_reg      <= idx_next;
            halted_reg   <= halted_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/wsdf_out_buf.sv @@
// Two-entry result register with skid stage for the deframer output.
`default_nettype none
module wsdf_out_buf (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wsdf_pkg::res_t  push_res,
    output logic            can_push,
    output logic            out_valid,
    input  wire logic       out_ready,
    output wsdf_pkg::res_t  out_res,
    output logic            skid_valid
);
    import wsdf_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_res_reg;
    res_t skid_res_reg;

    assign can_push   = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_res    = out_res_reg;
    assign skid_valid = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : push_res;
        end
        else if (push)
        begin
            skid_res_reg <= push_res;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/websocket_frame_deframer.sv @@
// Top level of the WebSocket frame deframer: config registers, parser and output buffer.
`default_nettype none
// The deframer takes one stream word per clock cycle while in_ready is high
// and registers each result in the output buffer, which presents it. Each
// frame begins with two header words, an optional 2- or 8-word big-endian
// extended length and four mask key words; the last mask word yields a header
// result carrying the payload length. Each payload word is then unmasked with
// the key word selected by its index modulo four, and the final one is marked
// last_of_frame. A zero-length frame is complete with its header result. A
// length above max_len_reg, or a raw 0xFF payload word while reject_ff_reg is
// set, produces one error result, after which every input word is accepted
// and dropped until reset. The sustained rate is one word per cycle while the
// output buffer has room, set by the parser's state update on each accepted
// word. A two-entry output buffer lets the input keep flowing while a result
// waits; input stalls only when both entries are full. Configuration is always
// ready and should be written only while the block is idle; writes to an
// unknown index are ignored. No memory clearing is needed after reset.
module websocket_frame_deframer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      stream_byte,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [wsdf_pkg::KIND_W-1:0]          kind,
    output logic [7:0]                           plain_byte,
    output logic [wsdf_pkg::LEN_W-1:0]           frame_length,
    output logic                                 last_of_frame,
    output logic                                 error_code,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [wsdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wsdf_pkg::LEN_W-1:0]      cfg_data
);
    import wsdf_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic             reject_ff_reg;

    logic        take;
    logic        push;
    logic        can_push;
    logic        skid_valid;
    res_t        parse_res;
    res_t        out_res;
    parse_stat_t stat;

    // Configuration registers; the port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            reject_ff_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_LEN:   max_len_reg   <= cfg_data;
                CFG_REJECT_FF: reject_ff_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // A word is accepted whenever the skid entry is free.
    assign in_ready = can_push;
    assign take     = in_valid && in_ready;
    assign push     = take && stat.res_valid;

    wsdf_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .stream_byte (stream_byte),
        .max_len     (max_len_reg),
        .reject_ff   (reject_ff_reg),
        .res         (parse_res),
        .stat        (stat)
    );

    wsdf_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_res   (parse_res),
        .can_push   (can_push),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res),
        .skid_valid (skid_valid)
    );

    assign kind          = out_res.kind;
    assign plain_byte    = out_res.plain_byte;
    assign frame_length  = out_res.frame_length;
    assign last_of_frame = out_res.last_of_frame;
    assign error_code    = out_res.error_code;

`ifndef SYNTHESIS
    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid |-> out_valid)
        else $error("skid entry holds a word while the output register is empty");

    // An error result halts the parser at once.
    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (parse_res.kind == KIND_ERROR)) |=> stat.halted)
        else $error("parser not halted after an error result");

    // A halted parser produces nothing more.
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        stat.halted |-> !stat.res_valid)
        else $error("halted parser produced a result");

    // A header result that ends its frame carries a zero length.
    a_empty_header: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.res_valid && (parse_res.kind == KIND_HEADER) && parse_res.last_of_frame)
        |-> (parse_res.frame_length == '0))
        else $error("last header result with nonzero length");
`endif

endmodule
`default_nettype wire
